[rtl/orp_pkg.sv]
`default_nettype none
package orp_pkg;

  // Ring geometry
  localparam int CAPACITY  = 1024;
  localparam int POP_LIMIT = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int REQ_W     = 7;
  localparam int CMP_W     = (CNT_W > REQ_W) ? CNT_W : REQ_W;
  localparam int HALF_W    = 32;
  localparam int POINT_W   = 2 * HALF_W;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [HALF_W-1:0] min_bits;
    logic [HALF_W-1:0] max_bits;
    logic [REQ_W-1:0]  request_count;
  } orp_in_t;

  typedef struct packed {
    logic              point_valid;
    logic [HALF_W-1:0] out_min_bits;
    logic [HALF_W-1:0] out_max_bits;
    logic              last_of_pop;
    logic [REQ_W-1:0]  points_taken;
  } orp_out_t;

endpackage
`default_nettype wire

[rtl/orp_ram.sv]
`default_nettype none
module orp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[rtl/overwriting_peak_ring.sv]
`default_nettype none
// Lossy ring of waveform peak points (min/max raw float pairs).
// Input channel: one beat per command (push, pop, clear) on in_valid_i /
// in_stall_o with payload in_data_i. Output channel: result beats on
// out_valid_o / out_stall_i with payload out_data_o.
// A push never fails; a full ring drops its oldest point.
// Neither a push nor a clear gives a result.
// A pop of n points stalls the input while n reads are issued (an empty
// pop counts as n = 1), one per cycle from the single read port of the
// point memory while a slot is free. Each result passes the read data
// register and then the output register, one per cycle if not stalled.
// An empty or zero-point pop gives one result marked last with count zero.
// When the receiver stalls, the output register holds its beat, the read
// data register behind it fills, and reads pause until a slot frees; no
// result is lost. Pushes and clears may be accepted while earlier pop
// results still wait on the output.
// Reset clears indexes, fill count and all valid flags at once; the point
// memory is not cleared and needs no pass.
module overwriting_peak_ring
  import orp_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire orp_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output orp_out_t      out_data_o
);

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]   fill_q, fill_d;
  logic [REQ_W-1:0]   rem_q, rem_d;
  logic [REQ_W-1:0]   total_q, total_d;

  logic               rd_vld_q, rd_vld_d;
  logic               rd_pv_q, rd_last_q;
  logic [REQ_W-1:0]   rd_cnt_q;
  logic               out_vld_q, out_vld_d;
  orp_out_t           out_q;

  logic               in_fire, out_adv, slot_free, issue, pop_empty;
  logic               ram_we;
  logic [POINT_W-1:0] ram_rdata;
  logic [REQ_W-1:0]   req_clamp, pop_n;
  logic [CMP_W-1:0]   fill_ext, req_ext;
  logic [IDX_W-1:0]   wr_next, rd_next;

  // Handshake and pipeline advance
  assign out_adv   = !out_vld_q || !out_stall_i;
  assign slot_free = !rd_vld_q || out_adv;
  assign pop_empty = (total_q == '0);
  assign in_fire   = in_valid_i && !in_stall_o;

  // Output decode of the sequencer
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    issue      = (state_q == ST_POP) && slot_free;
    ram_we     = (state_q == ST_IDLE) && in_fire &&
                 (opcode_e'(in_data_i.opcode) == OP_PUSH);
  end

  // Next slot with wrap at capacity
  assign wr_next = (wr_idx_q == IDX_W'(CAPACITY - 1)) ? '0 : wr_idx_q + 1'b1;
  assign rd_next = (rd_idx_q == IDX_W'(CAPACITY - 1)) ? '0 : rd_idx_q + 1'b1;

  // Size of a pop: request, limit and fill count
  assign req_clamp = (in_data_i.request_count > REQ_W'(POP_LIMIT)) ?
                     REQ_W'(POP_LIMIT) : in_data_i.request_count;
  assign fill_ext  = CMP_W'(fill_q);
  assign req_ext   = CMP_W'(req_clamp);
  assign pop_n     = (fill_ext < req_ext) ? REQ_W'(fill_ext) : REQ_W'(req_ext);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (opcode_e'(in_data_i.opcode) == OP_POP)) begin
          state_d = ST_POP;
        end
      end
      ST_POP: begin
        if (issue && (pop_empty || rem_q == REQ_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Ring indexes, fill count and pop counters
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    fill_d   = fill_q;
    rem_d    = rem_q;
    total_d  = total_q;
    if (state_q == ST_IDLE && in_fire) begin
      case (opcode_e'(in_data_i.opcode))
        OP_PUSH: begin
          wr_idx_d = wr_next;
          if (fill_q == CNT_W'(CAPACITY)) begin
            rd_idx_d = rd_next;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
        OP_POP: begin
          rem_d   = pop_n;
          total_d = pop_n;
        end
        OP_CLEAR: begin
          wr_idx_d = '0;
          rd_idx_d = '0;
          fill_d   = '0;
        end
        default: ;
      endcase
    end else if (issue && !pop_empty) begin
      rd_idx_d = rd_next;
      fill_d   = fill_q - 1'b1;
      rem_d    = rem_q - 1'b1;
    end
  end

  // Advance the read-data and output stages
  assign rd_vld_d  = slot_free ? issue : rd_vld_q;
  assign out_vld_d = out_adv ? rd_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_idx_q  <= '0;
      rd_idx_q  <= '0;
      fill_q    <= '0;
      rem_q     <= '0;
      total_q   <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_idx_q  <= wr_idx_d;
      rd_idx_q  <= rd_idx_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      total_q   <= total_d;
      rd_vld_q  <= rd_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Side info that travels with the read data
  always_ff @(posedge clk_i) begin
    if (slot_free && issue) begin
      rd_pv_q   <= !pop_empty;
      rd_last_q <= pop_empty || (rem_q == REQ_W'(1));
      rd_cnt_q  <= total_q;
    end
  end

  // Load the output beat
  always_ff @(posedge clk_i) begin
    if (out_adv && rd_vld_q) begin
      out_q.point_valid  <= rd_pv_q;
      out_q.out_min_bits <= rd_pv_q ? ram_rdata[HALF_W-1:0] : '0;
      out_q.out_max_bits <= rd_pv_q ? ram_rdata[POINT_W-1:HALF_W] : '0;
      out_q.last_of_pop  <= rd_last_q;
      out_q.points_taken <= rd_last_q ? rd_cnt_q : '0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  orp_ram #(
    .WIDTH (POINT_W),
    .DEPTH (CAPACITY)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_idx_q),
    .wdata_i ({in_data_i.max_bits, in_data_i.min_bits}),
    .re_i    (issue && !pop_empty),
    .raddr_i (rd_idx_q),
    .rdata_o (ram_rdata)
  );

endmodule
`default_nettype wire
